FILE: hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the particle pool simulation step block.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 48;
    localparam int IN_DW  = 136;
    localparam int OUT_DW = 136;

    // register indexes on the configuration port
    localparam logic [CFG_AW-1:0] CFG_GRAVITY  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_VEL_LOW  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_VEL_HIGH = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_LIFE     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_RATE     = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_SEED     = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_MODE     = 3'd6;

    localparam logic [23:0] LIFE_RESET = 24'h01_0000;
    localparam logic [31:0] SEED_RESET = 32'd1;
    localparam logic [2:0]  MODE_RESET = 3'd1;
    localparam logic [31:0] ACC_ONE    = 32'h0010_0000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BURST = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ACC,
        S_RATE_SCAN,
        S_PEND_SCAN,
        S_DRAW,
        S_SP_WAIT,
        S_SP_WRITE,
        S_INT_CHK,
        S_INT_V,
        S_INT_M,
        S_INT_P,
        S_RD_ISSUE,
        S_RD_DATA,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       latch;
        logic       ptr_clear;
        logic       ptr_load;
        logic       ptr_inc;
        logic       acc_add;
        logic       acc_clear;
        logic       gstep_calc;
        logic       burst_init;
        logic       draw;
        logic [1:0] axis;
        logic       spawn_write;
        logic       spawn_acc;
        logic       pend_end;
        logic       int_kill;
        logic       int_vel;
        logic       int_mul;
        logic       int_write;
        logic       rd_capture;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic dt_nz;
        logic emit;
        logic single_shot;
        logic rate_nz;
        logic pend_nz;
        logic acc_ge;
        logic ptr_end;
        logic cur_live;
        logic life_le;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/particle_pool_sim_step.sv
// ----------------------------------------------------------------------------
// particle_pool_sim_step
// Particle emitter with a fixed slot pool: burst, tick and slot read requests.
// ----------------------------------------------------------------------------
// Usage:
//  Requests enter on the s_axis channel; tuser carries the op (tick, burst,
//  read), tdata the dt, origin, burst size and slot index. Every request
//  gives exactly one status word on the m_axis channel.
//  The block works one request at a time. A read issues the slot address
//  and captures the data; a burst scans slots and spawns into dead ones. A
//  tick scans for spawns, then walks every slot for the integration pass.
//  Its cost is set by one state-memory read port walked slot by slot and
//  the read, multiply, write steps of each live slot; each spawn adds three
//  serial velocity draws through one multiplier.
//  A finished status word waits in an output register; the next request is
//  taken meanwhile and only its own completion stalls on m_axis_tready.
//  Configuration is written with i_cfg_we at any idle time and takes effect
//  on the next request; seed and start mode only act through reset.
//  Reset clears the live flags, counters and output valid, loads the random
//  state with the seed default and sets emitting per the mode default.
// ----------------------------------------------------------------------------
module particle_pool_sim_step import pps_pkg::*; #(
    parameter int POOL_SLOTS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // dt[15:0], origin_x, origin_y, origin_z, burst_size, slot_index[7:0]
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // alive_total[8:0], spawned_now, pending_left, emitting_now, spent,
    // slot_live, slot_pos_x, slot_pos_y, slot_pos_z, zero pad
    output logic [OUT_DW-1:0] m_axis_tdata
);

    t_cmd    cmd;
    t_status status;

    // sequencer: decides what the datapath does each cycle
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: pool memories, counters, arithmetic and output register
    pps_dp #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (m_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule

FILE: hdl/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: walks spawn scans, velocity draws and the integration pass.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_phase_rate, n_phase_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_axis       <= 2'd0;
            r_phase_rate <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_axis       <= n_axis;
            r_phase_rate <= n_phase_rate;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_axis       = r_axis;
        n_phase_rate = r_phase_rate;
        o_cmd        = '0;
        o_cmd.axis   = r_axis;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_START;
                end
            end
            S_START: begin
                case (i_status.op)
                    OP_TICK: begin
                        if (!i_status.dt_nz) begin
                            n_state = S_FIN;
                        end else begin
                            o_cmd.gstep_calc = 1'b1;
                            o_cmd.ptr_clear  = 1'b1;
                            if (i_status.emit && !i_status.single_shot && i_status.rate_nz) begin
                                n_state = S_ACC;
                            end else if (i_status.emit && i_status.pend_nz) begin
                                n_state = S_PEND_SCAN;
                            end else begin
                                n_state = S_INT_CHK;
                            end
                        end
                    end
                    OP_BURST: begin
                        o_cmd.burst_init = 1'b1;
                        o_cmd.ptr_clear  = 1'b1;
                        n_state          = S_PEND_SCAN;
                    end
                    OP_READ: begin
                        o_cmd.ptr_load = 1'b1;
                        n_state        = S_RD_ISSUE;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_RATE_SCAN;
            end
            S_RATE_SCAN: begin
                if (!i_status.acc_ge || i_status.ptr_end) begin
                    o_cmd.acc_clear = i_status.acc_ge;
                    if (i_status.emit && i_status.pend_nz) begin
                        n_state = S_PEND_SCAN;
                    end else begin
                        o_cmd.ptr_clear = 1'b1;
                        n_state         = S_INT_CHK;
                    end
                end else if (i_status.cur_live) begin
                    o_cmd.ptr_inc = 1'b1;
                end else begin
                    n_phase_rate = 1'b1;
                    n_axis       = 2'd0;
                    n_state      = S_DRAW;
                end
            end
            S_PEND_SCAN: begin
                if (!i_status.pend_nz || i_status.ptr_end) begin
                    o_cmd.pend_end = 1'b1;
                    if (i_status.op == OP_TICK) begin
                        o_cmd.ptr_clear = 1'b1;
                        n_state         = S_INT_CHK;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (i_status.cur_live) begin
                    o_cmd.ptr_inc = 1'b1;
                end else begin
                    n_phase_rate = 1'b0;
                    n_axis       = 2'd0;
                    n_state      = S_DRAW;
                end
            end
            S_DRAW: begin
                o_cmd.draw = 1'b1;
                n_axis     = r_axis + 2'd1;
                if (r_axis == 2'd2) begin
                    n_state = S_SP_WAIT;
                end
            end
            S_SP_WAIT: n_state = S_SP_WRITE;
            S_SP_WRITE: begin
                o_cmd.spawn_write = 1'b1;
                o_cmd.spawn_acc   = r_phase_rate;
                o_cmd.ptr_inc     = 1'b1;
                n_state           = r_phase_rate ? S_RATE_SCAN : S_PEND_SCAN;
            end
            S_INT_CHK: begin
                if (i_status.ptr_end) begin
                    n_state = S_FIN;
                end else if (!i_status.cur_live) begin
                    o_cmd.ptr_inc = 1'b1;
                end else begin
                    n_state = S_INT_V;
                end
            end
            S_INT_V: begin
                if (i_status.life_le) begin
                    o_cmd.int_kill = 1'b1;
                    o_cmd.ptr_inc  = 1'b1;
                    n_state        = S_INT_CHK;
                end else begin
                    o_cmd.int_vel = 1'b1;
                    n_state       = S_INT_M;
                end
            end
            S_INT_M: begin
                o_cmd.int_mul = 1'b1;
                n_state       = S_INT_P;
            end
            S_INT_P: begin
                o_cmd.int_write = 1'b1;
                o_cmd.ptr_inc   = 1'b1;
                n_state         = S_INT_CHK;
            end
            S_RD_ISSUE: n_state = S_RD_DATA;
            S_RD_DATA: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: hdl/pps_dp.sv
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: configuration, pool state, draw and integration arithmetic.
// ----------------------------------------------------------------------------
module pps_dp import pps_pkg::*; #(
    parameter int POOL_SLOTS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic [IN_DW-1:0]  i_in_data,
    input  logic [1:0]        i_in_op,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [OUT_DW-1:0] o_out_data,
    output logic              o_out_valid,
    input  logic              i_out_ready
);

    localparam int PW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = PW + 1;

    function automatic logic signed [15:0] q88(input logic [47:0] p, input logic [1:0] k);
        logic [15:0] v;
        case (k)
            2'd0:    v = p[15:0];
            2'd1:    v = p[31:16];
            default: v = p[47:32];
        endcase
        return signed'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (!v[33] && (v[32:31] != 2'b00)) begin
            return 32'sh7FFF_FFFF;
        end else if (v[33] && (v[32:31] != 2'b11)) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // configuration
    logic [47:0] r_gravity, r_vlo, r_vhi;
    logic [23:0] r_life_span;
    logic [15:0] r_rate;
    logic        r_auto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= '0;
            r_vlo       <= '0;
            r_vhi       <= '0;
            r_life_span <= LIFE_RESET;
            r_rate      <= '0;
            r_auto      <= MODE_RESET[2];
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GRAVITY:  r_gravity   <= i_cfg_data[47:0];
                CFG_VEL_LOW:  r_vlo       <= i_cfg_data[47:0];
                CFG_VEL_HIGH: r_vhi       <= i_cfg_data[47:0];
                CFG_LIFE:     r_life_span <= i_cfg_data[23:0];
                CFG_RATE:     r_rate      <= i_cfg_data[15:0];
                CFG_MODE:     r_auto      <= i_cfg_data[2];
                default: ; // seed and mode bits 1:0 act only through reset
            endcase
        end
    end

    // item and pool state
    t_op                 r_op;
    logic [15:0]         r_dt, r_burst;
    logic [95:0]         r_org;
    logic [7:0]          r_slot;
    logic [POOL_SLOTS-1:0] r_live;
    logic [CW-1:0]       r_alive, r_spawned, r_ptr;
    logic [31:0]         r_acc, r_rng;
    logic [15:0]         r_pend;
    logic                r_emit, r_single_shot, r_prod_vld, r_out_valid;

    logic signed [24:0]  r_gstep [3];
    logic signed [41:0]  r_prod;
    logic [1:0]          r_prod_axis;
    logic signed [31:0]  r_vel [3];
    logic signed [31:0]  r_vnew [3];
    logic signed [48:0]  r_pm [3];
    logic [23:0]         r_life_new;
    logic                r_rd_live;
    logic [95:0]         r_rd_pos;
    logic [OUT_DW-1:0]   r_out_data;

    logic [PW-1:0] addr;
    logic          cur_live, slot_ok;
    logic [31:0]   rng_next, rate_dt;
    logic [32:0]   acc_sum;
    logic [95:0]   pos_q, vel_q, pos_new, vel_wr, pos_wr;
    logic [23:0]   life_q, life_wr;
    logic          mem_we;
    logic signed [16:0] draw_diff;
    logic signed [41:0] draw_prod, prod_fl;
    logic signed [15:0] lo_sel;
    logic signed [31:0] lo_scaled, vel_draw;
    logic signed [32:0] gprod [3];
    logic signed [16:0] dt_s;

    assign addr     = r_ptr[PW-1:0];
    assign cur_live = r_live[addr];
    assign slot_ok  = ({24'd0, r_slot} < 32'(POOL_SLOTS));
    assign dt_s     = signed'({1'b0, r_dt});

    always_comb begin
        rng_next = r_rng ^ (r_rng << 13);
        rng_next = rng_next ^ (rng_next >> 17);
        rng_next = rng_next ^ (rng_next << 5);
    end

    assign rate_dt = r_rate * r_dt;
    assign acc_sum = {1'b0, r_acc} + {1'b0, rate_dt};

    // draw: (hi - lo) * u, then lo * 256 plus the floored product
    assign draw_diff = 17'(q88(r_vhi, i_cmd.axis)) - 17'(q88(r_vlo, i_cmd.axis));
    assign draw_prod = draw_diff * signed'({1'b0, rng_next[23:0]});
    assign lo_sel    = q88(r_vlo, r_prod_axis);
    assign lo_scaled = {{8{lo_sel[15]}}, lo_sel, 8'd0};
    assign prod_fl   = r_prod >>> 16;
    assign vel_draw  = lo_scaled + prod_fl[31:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            gprod[k] = q88(r_gravity, 2'(k)) * dt_s;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [48:0] st;
            st = r_pm[k] >>> 16;
            pos_new[32*k +: 32] = sat32(34'(signed'(pos_q[32*k +: 32])) + st[33:0]);
        end
    end

    assign mem_we  = i_cmd.spawn_write | i_cmd.int_write;
    assign pos_wr  = i_cmd.spawn_write ? r_org : pos_new;
    assign vel_wr  = i_cmd.spawn_write ? {r_vel[2], r_vel[1], r_vel[0]}
                                       : {r_vnew[2], r_vnew[1], r_vnew[0]};
    assign life_wr = i_cmd.spawn_write ? r_life_span : r_life_new;

    pps_ram #(.WIDTH(96), .DEPTH(POOL_SLOTS)) u_pos_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(addr), .i_wdata(pos_wr),
        .i_raddr(addr), .o_rdata(pos_q)
    );
    pps_ram #(.WIDTH(96), .DEPTH(POOL_SLOTS)) u_vel_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(addr), .i_wdata(vel_wr),
        .i_raddr(addr), .o_rdata(vel_q)
    );
    pps_ram #(.WIDTH(24), .DEPTH(POOL_SLOTS)) u_life_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(addr), .i_wdata(life_wr),
        .i_raddr(addr), .o_rdata(life_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live        <= '0;
            r_alive       <= '0;
            r_spawned     <= '0;
            r_ptr         <= '0;
            r_acc         <= '0;
            r_rng         <= SEED_RESET;
            r_pend        <= '0;
            r_emit        <= MODE_RESET[0];
            r_single_shot <= MODE_RESET[1];
            r_prod_vld    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.draw;
            if (i_cmd.latch)     r_spawned <= '0;
            if (i_cmd.ptr_clear) r_ptr <= '0;
            if (i_cmd.ptr_load)  r_ptr <= CW'(r_slot);
            if (i_cmd.ptr_inc)   r_ptr <= r_ptr + 1'b1;
            if (i_cmd.acc_add)   r_acc <= acc_sum[32] ? '1 : acc_sum[31:0];
            if (i_cmd.acc_clear) r_acc <= '0;
            if (i_cmd.burst_init) begin
                r_single_shot <= 1'b1;
                r_emit        <= 1'b1;
                r_pend        <= (r_burst == 16'd0) ? {4'd0, r_rate[15:4]} : r_burst;
            end
            if (i_cmd.draw) r_rng <= rng_next;
            if (i_cmd.spawn_write) begin
                r_live[addr] <= 1'b1;
                r_alive      <= r_alive + 1'b1;
                r_spawned    <= r_spawned + 1'b1;
                if (i_cmd.spawn_acc) begin
                    r_acc <= r_acc - ACC_ONE;
                end else begin
                    r_pend <= r_pend - 16'd1;
                end
            end
            if (i_cmd.pend_end && r_single_shot && (r_pend == 16'd0)) r_emit <= 1'b0;
            if (i_cmd.int_kill) begin
                r_live[addr] <= 1'b0;
                r_alive      <= r_alive - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= t_op'(i_in_op);
            r_dt    <= i_in_data[15:0];
            r_org   <= i_in_data[111:16];
            r_burst <= i_in_data[127:112];
            r_slot  <= i_in_data[135:128];
        end
        if (i_cmd.gstep_calc) begin
            for (int k = 0; k < 3; k++) begin
                r_gstep[k] <= 25'(gprod[k] >>> 8);
            end
        end
        if (i_cmd.draw) begin
            r_prod      <= draw_prod;
            r_prod_axis <= i_cmd.axis;
        end
        if (r_prod_vld) r_vel[r_prod_axis] <= vel_draw;
        if (i_cmd.int_vel) begin
            r_life_new <= life_q - {8'd0, r_dt};
            for (int k = 0; k < 3; k++) begin
                r_vnew[k] <= sat32(34'(signed'(vel_q[32*k +: 32])) + 34'(r_gstep[k]));
            end
        end
        if (i_cmd.int_mul) begin
            for (int k = 0; k < 3; k++) begin
                r_pm[k] <= r_vnew[k] * dt_s;
            end
        end
        if (i_cmd.rd_capture) begin
            r_rd_live <= slot_ok && cur_live;
            r_rd_pos  <= (slot_ok && cur_live) ? pos_q : '0;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {3'd0,
                           (r_op == OP_READ) ? r_rd_pos : 96'd0,
                           (r_op == OP_READ) ? r_rd_live : 1'b0,
                           r_auto && r_single_shot && (r_alive == '0)
                               && (r_pend == 16'd0) && !r_emit,
                           r_emit,
                           r_pend,
                           9'(r_spawned),
                           9'(r_alive)};
        end
    end

    assign o_out_data  = r_out_data;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_status             = '0;
        o_status.op          = r_op;
        o_status.dt_nz       = (r_dt != 16'd0);
        o_status.emit        = r_emit;
        o_status.single_shot = r_single_shot;
        o_status.rate_nz     = (r_rate != 16'd0);
        o_status.pend_nz     = (r_pend != 16'd0);
        o_status.acc_ge      = (r_acc >= ACC_ONE);
        o_status.ptr_end     = (r_ptr == CW'(POOL_SLOTS));
        o_status.cur_live    = cur_live;
        o_status.life_le     = (life_q <= {8'd0, r_dt});
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    a_alive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive <= CW'(POOL_SLOTS))
        else $error("live count above pool size");
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= CW'(POOL_SLOTS))
        else $error("slot pointer past pool end");
    a_spawn_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.spawn_write |-> !cur_live && (r_ptr != CW'(POOL_SLOTS)))
        else $error("spawn into a live slot");
    a_int_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.int_write |-> cur_live && $past(i_cmd.int_mul))
        else $error("integration write without a live slot");

endmodule

FILE: test/particle_pool_sim_step_tb.sv
// ----------------------------------------------------------------------------
// particle_pool_sim_step_tb
// Self-checking bench for the particle pool block. Requests (tick, burst,
// read, unused op) are streamed in with random gaps and the status words are
// taken with random back-pressure. A software copy of the pool
// (spawn, rate accumulator, xorshift velocity draws, semi-implicit Euler
// integration) predicts every status word. The run steps through several
// register settings, extremes included.
// ----------------------------------------------------------------------------
module particle_pool_sim_step_tb import pps_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 256;
    localparam longint CYCLE_LIMIT = 8_000_000;

    typedef struct {
        t_op         op;
        logic [15:0] dt;
        logic [31:0] ox, oy, oz;
        logic [15:0] bsize;
        logic [7:0]  slot;
    } t_request;

    typedef struct {
        logic [8:0]  alive;
        logic [8:0]  spawned;
        logic [15:0] pend;
        logic        emit;
        logic        spent;
        logic        slive;
        logic [31:0] px, py, pz;
    } t_status_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;

    particle_pool_sim_step i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pool mirror: register copies and particle state
    // ------------------------------------------------------------------
    logic [47:0] grav_r = '0, vlo_r = '0, vhi_r = '0;
    logic [23:0] life_r = LIFE_RESET;
    logic [15:0] rate_r = '0;
    logic [2:0]  mode_r = MODE_RESET;

    bit          slot_alive [SLOTS];
    int          pos_x [SLOTS], pos_y [SLOTS], pos_z [SLOTS];
    int          vel_x [SLOTS], vel_y [SLOTS], vel_z [SLOTS];
    logic [23:0] life_left [SLOTS];
    logic [31:0] rng_state = SEED_RESET;
    logic [31:0] rate_acc = '0;
    logic [15:0] burst_pending = '0;
    bit          emitting = MODE_RESET[0];
    bit          single_shot = MODE_RESET[1];

    t_request     request_q [$];
    t_status_word status_q [$];
    int           fail_count = 0;
    int           idle_pct = 0;
    bit           no_idle = 1'b0;

    function automatic longint q88(logic [47:0] p, int k);
        return longint'($signed(p[16*k +: 16]));
    endfunction

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    function automatic logic [31:0] xorshift_next();
        logic [31:0] s;
        s = rng_state;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        rng_state = s;
        return s;
    endfunction

    // lo + floor((hi - lo) * u), u a 24-bit fraction, result Q16.16
    function automatic int draw_velocity(int k);
        longint lo, hi, u;
        lo = q88(vlo_r, k);
        hi = q88(vhi_r, k);
        u  = longint'({8'd0, xorshift_next() & 32'h00FF_FFFF});
        return sat32(lo * 256 + (((hi - lo) * u) >>> 16));
    endfunction

    function automatic int first_dead();
        for (int i = 0; i < SLOTS; i++)
            if (!slot_alive[i]) return i;
        return -1;
    endfunction

    function automatic void spawn_slot(int s, t_request r);
        pos_x[s] = r.ox;
        pos_y[s] = r.oy;
        pos_z[s] = r.oz;
        vel_x[s] = draw_velocity(0);
        vel_y[s] = draw_velocity(1);
        vel_z[s] = draw_velocity(2);
        life_left[s] = life_r;
        slot_alive[s] = 1'b1;
    endfunction

    function automatic int spawn_up_to(int count, t_request r);
        int n;
        int s;
        n = 0;
        while (n < count) begin
            s = first_dead();
            if (s < 0) break;
            spawn_slot(s, r);
            n++;
        end
        return n;
    endfunction

    function automatic int tick_pool(t_request r);
        int     made;
        int     s;
        longint acc;
        longint dt;
        longint gx, gy, gz;
        made = 0;
        dt = longint'(r.dt);
        if (emitting) begin
            if (!single_shot && rate_r != 0) begin
                acc = longint'(rate_acc) + longint'(rate_r) * dt;
                rate_acc = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                while (rate_acc >= ACC_ONE) begin
                    s = first_dead();
                    if (s < 0) begin
                        rate_acc = '0;
                        break;
                    end
                    spawn_slot(s, r);
                    made++;
                    rate_acc = rate_acc - ACC_ONE;
                end
            end
            if (burst_pending != 0) begin
                s = spawn_up_to(int'(burst_pending), r);
                made += s;
                burst_pending = burst_pending - 16'(s);
                if (single_shot && burst_pending == 0) emitting = 1'b0;
            end
        end
        gx = (q88(grav_r, 0) * dt) >>> 8;
        gy = (q88(grav_r, 1) * dt) >>> 8;
        gz = (q88(grav_r, 2) * dt) >>> 8;
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_alive[i]) continue;
            if (longint'(life_left[i]) <= dt) begin
                slot_alive[i] = 1'b0;
                continue;
            end
            life_left[i] = life_left[i] - r.dt;
            vel_x[i] = sat32(longint'(vel_x[i]) + gx);
            vel_y[i] = sat32(longint'(vel_y[i]) + gy);
            vel_z[i] = sat32(longint'(vel_z[i]) + gz);
            pos_x[i] = sat32(longint'(pos_x[i]) + ((longint'(vel_x[i]) * dt) >>> 16));
            pos_y[i] = sat32(longint'(pos_y[i]) + ((longint'(vel_y[i]) * dt) >>> 16));
            pos_z[i] = sat32(longint'(pos_z[i]) + ((longint'(vel_z[i]) * dt) >>> 16));
        end
        return made;
    endfunction

    // Advance the mirror by one request and return the status it must give.
    function automatic t_status_word pool_status(t_request r);
        t_status_word w;
        int made;
        int req;
        int live;
        made = 0;
        live = 0;
        w = '{default: '0};
        case (r.op)
            OP_TICK: begin
                if (r.dt != 0) made = tick_pool(r);
            end
            OP_BURST: begin
                req = (r.bsize == 0) ? int'(rate_r >> 4) : int'(r.bsize);
                single_shot = 1'b1;
                emitting = 1'b1;
                burst_pending = '0;
                made = spawn_up_to(req, r);
                burst_pending = 16'(req - made);
                if (burst_pending == 0) emitting = 1'b0;
            end
            OP_READ: begin
                if (slot_alive[r.slot]) begin
                    w.slive = 1'b1;
                    w.px = pos_x[r.slot];
                    w.py = pos_y[r.slot];
                    w.pz = pos_z[r.slot];
                end
            end
            default: ;
        endcase
        for (int i = 0; i < SLOTS; i++)
            if (slot_alive[i]) live++;
        w.alive   = 9'(live);
        w.spawned = 9'(made);
        w.pend    = burst_pending;
        w.emit    = emitting;
        w.spent   = mode_r[2] && single_shot && live == 0 && burst_pending == 0 && !emitting;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    t_request cur_req;
    int       src_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            // predict on acceptance so the mirror follows the block's order
            if (s_axis_tvalid && s_axis_tready)
                status_q.insert(status_q.size(), pool_status(cur_req));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (request_q.size() != 0 && !no_idle
                             && $urandom_range(99, 0) < idle_pct) begin
                    src_gap <= $urandom_range(10, 0);
                    s_axis_tvalid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    cur_req = request_q.pop_front();
                    s_axis_tdata <= {cur_req.slot, cur_req.bsize, cur_req.oz,
                                     cur_req.oy, cur_req.ox, cur_req.dt};
                    s_axis_tuser <= cur_req.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Status monitor
    // ------------------------------------------------------------------
    int sink_gap = 0;

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_status_word want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_q.size() == 0) begin
                    $display("%0t: status word with none expected, actual %0h",
                             $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    check_field("alive_total",  want.alive,   m_axis_tdata[8:0]);
                    check_field("spawned_now",  want.spawned, m_axis_tdata[17:9]);
                    check_field("pending_left", want.pend,    m_axis_tdata[33:18]);
                    check_field("emitting_now", want.emit,    m_axis_tdata[34]);
                    check_field("spent",        want.spent,   m_axis_tdata[35]);
                    check_field("slot_live",    want.slive,   m_axis_tdata[36]);
                    check_field("slot_pos_x",   want.px,      m_axis_tdata[68:37]);
                    check_field("slot_pos_y",   want.py,      m_axis_tdata[100:69]);
                    check_field("slot_pos_z",   want.pz,      m_axis_tdata[132:101]);
                end
            end
            if (sink_gap != 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(99, 0) < idle_pct) begin
                sink_gap <= $urandom_range(10, 0);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // hard stop
    longint cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("particle_pool_sim_step_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send(t_op op, logic [15:0] dt, logic [31:0] ox, logic [31:0] oy,
                        logic [31:0] oz, logic [15:0] bsize, logic [7:0] slot);
        t_request r;
        r.op = op;
        r.dt = dt;
        r.ox = ox;
        r.oy = oy;
        r.oz = oz;
        r.bsize = bsize;
        r.slot = slot;
        request_q.insert(request_q.size(), r);
    endtask

    // hold until every request is answered, then let the block go quiet
    task automatic drain();
        do @(negedge i_clk);
        while (request_q.size() != 0 || s_axis_tvalid || status_q.size() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_GRAVITY:  grav_r = val;
            CFG_VEL_LOW:  vlo_r = val;
            CFG_VEL_HIGH: vhi_r = val;
            CFG_LIFE:     life_r = val[23:0];
            CFG_RATE:     rate_r = val[15:0];
            CFG_MODE:     mode_r = val[2:0];
            default: ; // the seed acts only through reset
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_origin();
        if ($urandom_range(1, 0)) return $urandom();
        return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(19, 0))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom());
            default: return 16'($urandom_range(20000, 1));
        endcase
    endfunction

    task automatic rand_requests(int n, bit with_bursts);
        int   pick;
        t_op  op;
        logic [15:0] bsize;
        logic [7:0]  slot;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99, 0);
            if (pick < 50) op = OP_TICK;
            else if (pick < 85) op = OP_READ;
            else if (pick < 97) op = with_bursts ? OP_BURST : OP_TICK;
            else op = OP_NONE;
            case ($urandom_range(9, 0))
                0:       bsize = 16'd0;
                1:       bsize = 16'($urandom());
                default: bsize = 16'($urandom_range(40, 1));
            endcase
            slot = ($urandom_range(9, 0) < 7) ? 8'($urandom_range(31, 0)) : 8'($urandom());
            send(op, rand_dt(), rand_origin(), rand_origin(), rand_origin(), bsize, slot);
        end
    endtask

    task automatic rand_setting(bit with_idle);
        idle_pct = with_idle ? $urandom_range(40, 0) : 0;
        cfg_write(CFG_GRAVITY,  {16'($urandom()), 32'($urandom())});
        cfg_write(CFG_VEL_LOW,  {16'($urandom()), 32'($urandom())});
        cfg_write(CFG_VEL_HIGH, {16'($urandom()), 32'($urandom())});
        cfg_write(CFG_LIFE,     48'($urandom_range(32'h0002_0000, 32'h0000_1000)));
        cfg_write(CFG_RATE,     48'($urandom_range(16'h0800, 0)));
        cfg_write(CFG_SEED,     48'($urandom()));
        cfg_write(CFG_MODE,     48'($urandom_range(7, 0)));
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_alive[i] = 1'b0;
            pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
            vel_x[i] = 0; vel_y[i] = 0; vel_z[i] = 0;
            life_left[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero dt, unused op, dead read, empty tick
        idle_pct = 20;
        send(OP_TICK, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 16'd0, 8'd0);
        send(OP_NONE, 16'hFFFF, 32'd0, 32'd0, 32'd0, 16'hFFFF, 8'hFF);
        send(OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 8'd0);
        send(OP_TICK, 16'd1, 32'd0, 32'd0, 32'd0, 16'd0, 8'd0);
        drain();

        // saturating rate: full pool clears the accumulator; the zero seed write
        // has no effect; y velocity bounds reversed
        cfg_write(CFG_GRAVITY,  {16'h8000, 16'h7FFF, 16'h0100});
        cfg_write(CFG_VEL_LOW,  {16'hFB00, 16'h0500, 16'h8000});
        cfg_write(CFG_VEL_HIGH, {16'h0500, 16'hFB00, 16'h7FFF});
        cfg_write(CFG_LIFE,     48'h00_4000);
        cfg_write(CFG_RATE,     48'hFFFF);
        cfg_write(CFG_SEED,     48'd0);
        cfg_write(CFG_MODE,     48'd4);
        send(OP_TICK, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 16'd0, 8'd0);
        send(OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 8'd0);
        send(OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 8'hFF);
        send(OP_TICK, 16'h2000, 32'd0, 32'd0, 32'd0, 16'd0, 8'd0);
        send(OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 8'd7);
        send(OP_TICK, 16'hFFFF, 32'd0, 32'd0, 32'd0, 16'd0, 8'd0);
        drain();

        // continuous emission only: no burst, or one-shot would latch
        cfg_write(CFG_RATE, 48'h0400);
        rand_requests(200, 1'b0);
        drain();

        // bursts: zero size takes the rate integer part, overflow stays pending
        cfg_write(CFG_LIFE, 48'h00_8000);
        send(OP_BURST, 16'd0, 32'h0001_0000, 32'd0, 32'hFFFF_0000, 16'd0, 8'd0);
        send(OP_BURST, 16'd0, 32'd0, 32'd0, 32'd0, 16'd300, 8'd0);
        send(OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 8'd255);
        send(OP_TICK, 16'h4000, 32'h1234_5678, 32'd0, 32'd0, 16'd0, 8'd0);
        send(OP_BURST, 16'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF, 8'd0);
        send(OP_TICK, 16'hFFFF, 32'd0, 32'd0, 32'd0, 16'd0, 8'd0);
        send(OP_TICK, 16'hFFFF, 32'd0, 32'd0, 32'd0, 16'd0, 8'd0);
        send(OP_TICK, 16'hFFFF, 32'd0, 32'd0, 32'd0, 16'd0, 8'd0);
        drain();
        rand_requests(200, 1'b1);
        drain();

        // extremes: long life and widest bounds drive the adds into saturation
        cfg_write(CFG_GRAVITY,  48'hFFFF_FFFF_FFFF);
        cfg_write(CFG_VEL_LOW,  48'h8000_8000_8000);
        cfg_write(CFG_VEL_HIGH, 48'h7FFF_7FFF_7FFF);
        cfg_write(CFG_LIFE,     48'hFF_FFFF);
        cfg_write(CFG_RATE,     48'hFFFF);
        cfg_write(CFG_SEED,     48'hFFFF_FFFF);
        cfg_write(CFG_MODE,     48'd7);
        send(OP_BURST, 16'd0, 32'h7FFF_0000, 32'h8001_0000, 32'd0, 16'd3, 8'd0);
        for (int i = 0; i < 3; i++)
            send(OP_READ, 16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 8'(i));
        rand_requests(100, 1'b0);
        drain();

        // random settings
        for (int p = 0; p < 2; p++) begin
            rand_setting(1'b1);
            rand_requests(150, 1'b1);
            drain();
        end

        // final stretch at full rate
        rand_setting(1'b0);
        no_idle = 1'b1;
        rand_requests(150, 1'b1);
        drain();

        if (fail_count == 0 && status_q.size() == 0)
            $display("particle_pool_sim_step_tb OK");
        else
            $display("particle_pool_sim_step_tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
hdl/pps_pkg.sv
hdl/pps_ram.sv
hdl/pps_ctrl.sv
hdl/pps_dp.sv
hdl/particle_pool_sim_step.sv
test/particle_pool_sim_step_tb.sv
